>>> src/lsa_pkg.sv
package lsa_pkg;

   // Default configuration
   localparam int NUM_STYLES_DEF  = 64;
   localparam int MAX_PATTERN_DEF = 64;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int STYLE_W  = 6;
   localparam int POS_W    = 6;
   localparam int LEVEL_W  = 5;
   localparam int LEN_W    = 7;
   localparam int FRAME_W  = 32;
   localparam int FRAC_W   = 8;
   localparam int LIGHT_W  = 10;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE_LEVEL = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET_LENGTH  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EVALUATE    = 2'd2;

   // Light constants
   localparam logic [LIGHT_W-1:0] UNUSED_LIGHT = 10'd264;
   localparam int                 STEP_LIGHT   = 22;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL    = 5'd25;

   // Remainder unit: dividend bits retired per cycle
   localparam int MOD_DIGITS = 8;

   // Blend sum k1*(256-f) + k2*f, up to 31*256
   localparam int BLEND_SUM_W = LEVEL_W + FRAC_W;

   typedef struct packed {
      logic               start;
      logic [FRAME_W-1:0] dividend;
      logic [LEN_W-1:0]   divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] rem;
   } mod_rsp_type;

   typedef struct packed {
      logic               start;
      logic [LEVEL_W-1:0] k1;
      logic [LEVEL_W-1:0] k2;
      logic [FRAC_W-1:0]  frac;
   } blend_req_type;

   typedef struct packed {
      logic               done;
      logic [LIGHT_W-1:0] value;
   } blend_rsp_type;

endpackage

>>> src/light_style_animator.sv
// Write and length words are stored while idle and leave the block ready.
// An evaluate word walks the styles one at a time: a used style waits on the
// 8-bit-per-cycle remainder unit, then takes two pattern reads and a two-stage
// blend; an unused style goes to output after its length read. Output stalls add waits.
// Ready returns once the last result is registered.
// Synchronous reset clears the sequencer and marks every style unused.
module light_style_animator #(
   parameter int NUM_STYLES  = lsa_pkg::NUM_STYLES_DEF,
   parameter int MAX_PATTERN = lsa_pkg::MAX_PATTERN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lsa_pkg::ACTION_W-1:0] req_action,
   input  logic [lsa_pkg::STYLE_W-1:0]  req_style_index,
   input  logic [lsa_pkg::POS_W-1:0]    req_position,
   input  logic [lsa_pkg::LEVEL_W-1:0]  req_level,
   input  logic [lsa_pkg::LEN_W-1:0]    req_pattern_length,
   input  logic [lsa_pkg::FRAME_W-1:0]  req_frame_count,
   input  logic [lsa_pkg::FRAC_W-1:0]   req_frame_fraction,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lsa_pkg::STYLE_W-1:0]  rsp_result_style,
   output logic [lsa_pkg::LIGHT_W-1:0]  rsp_light_value,
   output logic                         rsp_last
);

   localparam int DEPTH  = NUM_STYLES * MAX_PATTERN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIDX_W = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
   localparam int LEN_W  = lsa_pkg::LEN_W;
   localparam int SUM_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LEN   = 4'd1;
   localparam logic [3:0] ST_LCHK  = 4'd2;
   localparam logic [3:0] ST_MOD   = 4'd3;
   localparam logic [3:0] ST_RD1   = 4'd4;
   localparam logic [3:0] ST_RD2   = 4'd5;
   localparam logic [3:0] ST_KB    = 4'd6;
   localparam logic [3:0] ST_BLEND = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]                   st_ff, st_in;
   logic [SIDX_W-1:0]            j_ff, j_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic [lsa_pkg::FRAME_W-1:0]  frame_ff, frame_in;
   logic [lsa_pkg::FRAC_W-1:0]   frac_ff, frac_in;
   logic [LEN_W-1:0]             rem_ff, rem_in;
   logic [LEN_W-1:0]             nxt_ff, nxt_in;
   logic [lsa_pkg::LEVEL_W-1:0]  k1_ff, k1_in;
   logic [lsa_pkg::LIGHT_W-1:0]  val_ff, val_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lsa_pkg::STYLE_W-1:0]  rsp_style_ff, rsp_style_in;
   logic [lsa_pkg::LIGHT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         acc;
   logic                         style_ok;
   logic                         pos_ok;
   logic                         lvl_we;
   logic [ADDR_W-1:0]            lvl_waddr;
   logic [lsa_pkg::LEVEL_W-1:0]  lvl_wdata;
   logic [ADDR_W-1:0]            lvl_raddr;
   logic [lsa_pkg::LEVEL_W-1:0]  lvl_rdata;
   logic                         len_we;
   logic [LEN_W-1:0]             len_wdata;
   logic [LEN_W-1:0]             len_rdata;
   logic [LEN_W-1:0]             pos_sel;
   logic [LEN_W:0]               rem_inc;
   logic                         is_last;

   lsa_pkg::mod_req_type         mod_req;
   lsa_pkg::mod_rsp_type         mod_rsp;
   lsa_pkg::blend_req_type       blend_req;
   lsa_pkg::blend_rsp_type       blend_rsp;

   // Input decode
   assign req_ready = (st_ff == ST_IDLE);
   assign acc       = req_valid && req_ready;
   assign style_ok  = int'(req_style_index) < NUM_STYLES;
   assign pos_ok    = int'(req_position) < MAX_PATTERN;

   assign lvl_we    = acc && (req_action == lsa_pkg::ACT_WRITE_LEVEL) && style_ok && pos_ok;
   assign lvl_waddr = ADDR_W'(int'(req_style_index) * MAX_PATTERN + int'(req_position));
   assign lvl_wdata = (req_level > lsa_pkg::TOP_LEVEL) ? lsa_pkg::TOP_LEVEL : req_level;

   assign len_we    = acc && (req_action == lsa_pkg::ACT_SET_LENGTH) && style_ok;
   assign len_wdata = (int'(req_pattern_length) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                               : req_pattern_length;

   assign pos_sel   = (st_ff == ST_RD2) ? nxt_ff : rem_ff;
   assign lvl_raddr = ADDR_W'(SUM_W'(base_ff) + SUM_W'(pos_sel));

   lsa_store #(
      .NUM_STYLES  (NUM_STYLES),
      .MAX_PATTERN (MAX_PATTERN),
      .ADDR_W      (ADDR_W),
      .SIDX_W      (SIDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .lvl_we    (lvl_we),
      .lvl_waddr (lvl_waddr),
      .lvl_wdata (lvl_wdata),
      .lvl_raddr (lvl_raddr),
      .lvl_rdata (lvl_rdata),
      .len_we    (len_we),
      .len_waddr (SIDX_W'(req_style_index)),
      .len_wdata (len_wdata),
      .len_raddr (j_ff),
      .len_rdata (len_rdata)
   );

   assign mod_req.start    = (st_ff == ST_LCHK) && (len_rdata != '0);
   assign mod_req.dividend = frame_ff;
   assign mod_req.divisor  = len_rdata;

   lsa_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign blend_req.start = (st_ff == ST_KB);
   assign blend_req.k1    = k1_ff;
   assign blend_req.k2    = lvl_rdata;
   assign blend_req.frac  = frac_ff;

   lsa_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_req (blend_req),
      .blend_rsp (blend_rsp)
   );

   // next position wraps at the length; with zero fraction both reads hit the same spot
   assign rem_inc = {1'b0, mod_rsp.rem} + 1'b1;
   assign is_last = (j_ff == SIDX_W'(NUM_STYLES - 1));

   always_comb begin
      st_in        = st_ff;
      j_in         = j_ff;
      base_in      = base_ff;
      frame_in     = frame_ff;
      frac_in      = frac_ff;
      rem_in       = rem_ff;
      nxt_in       = nxt_ff;
      k1_in        = k1_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_style_in = rsp_style_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc && (req_action == lsa_pkg::ACT_EVALUATE)) begin
               frame_in = req_frame_count;
               frac_in  = req_frame_fraction;
               j_in     = '0;
               base_in  = '0;
               st_in    = ST_LEN;
            end
         end
         ST_LEN: begin
            st_in = ST_LCHK;
         end
         ST_LCHK: begin
            if (len_rdata == '0) begin
               val_in = lsa_pkg::UNUSED_LIGHT;
               st_in  = ST_OUT;
            end else begin
               st_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               rem_in = mod_rsp.rem;
               if (frac_ff == '0) begin
                  nxt_in = mod_rsp.rem;
               end else if (rem_inc == {1'b0, len_rdata}) begin
                  nxt_in = '0;
               end else begin
                  nxt_in = rem_inc[LEN_W-1:0];
               end
               st_in = ST_RD1;
            end
         end
         ST_RD1: begin
            st_in = ST_RD2;
         end
         ST_RD2: begin
            k1_in = lvl_rdata;
            st_in = ST_KB;
         end
         ST_KB: begin
            st_in = ST_BLEND;
         end
         ST_BLEND: begin
            if (blend_rsp.done) begin
               val_in = blend_rsp.value;
               st_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_style_in = lsa_pkg::STYLE_W'(j_ff);
               rsp_value_in = val_ff;
               rsp_last_in  = is_last;
               if (is_last) begin
                  st_in = ST_IDLE;
               end else begin
                  j_in    = j_ff + 1'b1;
                  base_in = ADDR_W'(int'(base_ff) + MAX_PATTERN);
                  st_in   = ST_LEN;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      base_ff      <= base_in;
      frame_ff     <= frame_in;
      frac_ff      <= frac_in;
      rem_ff       <= rem_in;
      nxt_ff       <= nxt_in;
      k1_ff        <= k1_in;
      val_ff       <= val_in;
      rsp_style_ff <= rsp_style_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_style = rsp_style_ff;
   assign rsp_light_value  = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   a_last_style: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_style_ff == lsa_pkg::STYLE_W'(NUM_STYLES - 1)))
      else $error("last flag on a style other than the final one");

   a_mod_in_state: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (st_ff == ST_MOD))
      else $error("remainder finished outside its wait state");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (mod_rsp.rem < len_rdata))
      else $error("remainder not below the style length");

   a_blend_in_state: assert property (@(posedge clock) disable iff (reset)
      blend_rsp.done |-> (st_ff == ST_BLEND))
      else $error("blend finished outside its wait state");

endmodule

>>> src/lsa_mod_unit.sv
module lsa_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  lsa_pkg::mod_req_type mod_req,
   output lsa_pkg::mod_rsp_type mod_rsp
);

   localparam int FRAME_W = lsa_pkg::FRAME_W;
   localparam int LEN_W   = lsa_pkg::LEN_W;
   localparam int STEPS   = lsa_pkg::MOD_DIGITS;
   localparam int CYCLES  = FRAME_W / STEPS;
   localparam int CNT_W   = (CYCLES > 1) ? $clog2(CYCLES) : 1;

   logic [FRAME_W-1:0] dvd_ff;
   logic [LEN_W-1:0]   div_ff;
   logic [LEN_W-1:0]   rem_ff;
   logic [LEN_W-1:0]   rem_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   // Restoring remainder, STEPS dividend bits per cycle
   always_comb begin
      logic [LEN_W:0]   t;
      logic [LEN_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         t = {r, dvd_ff[FRAME_W-1-i]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         r = t[LEN_W-1:0];
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mod_req.start) begin
            dvd_ff  <= mod_req.dividend;
            div_ff  <= mod_req.divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dvd_ff <= dvd_ff << STEPS;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mod_rsp.done = done_ff;
   assign mod_rsp.rem  = rem_ff;

endmodule

>>> src/lsa_store.sv
module lsa_store #(
   parameter int NUM_STYLES  = lsa_pkg::NUM_STYLES_DEF,
   parameter int MAX_PATTERN = lsa_pkg::MAX_PATTERN_DEF,
   parameter int ADDR_W      = 12,
   parameter int SIDX_W      = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        lvl_we,
   input  logic [ADDR_W-1:0]           lvl_waddr,
   input  logic [lsa_pkg::LEVEL_W-1:0] lvl_wdata,
   input  logic [ADDR_W-1:0]           lvl_raddr,
   output logic [lsa_pkg::LEVEL_W-1:0] lvl_rdata,
   input  logic                        len_we,
   input  logic [SIDX_W-1:0]           len_waddr,
   input  logic [lsa_pkg::LEN_W-1:0]   len_wdata,
   input  logic [SIDX_W-1:0]           len_raddr,
   output logic [lsa_pkg::LEN_W-1:0]   len_rdata
);

   localparam int DEPTH = NUM_STYLES * MAX_PATTERN;

   logic [lsa_pkg::LEVEL_W-1:0] lvl_mem [DEPTH];
   logic [lsa_pkg::LEVEL_W-1:0] lvl_q_ff;

   logic [lsa_pkg::LEN_W-1:0]   len_mem [NUM_STYLES];
   logic [lsa_pkg::LEN_W-1:0]   len_q_ff;
   logic [NUM_STYLES-1:0]       len_vld_ff;
   logic                        len_q_vld_ff;

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_q_ff <= lvl_mem[lvl_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_q_ff <= len_mem[len_raddr];
   end

   // Unwritten lengths read as zero (style unused)
   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff   <= '0;
         len_q_vld_ff <= 1'b0;
      end else begin
         if (len_we) begin
            len_vld_ff[len_waddr] <= 1'b1;
         end
         len_q_vld_ff <= len_vld_ff[len_raddr];
      end
   end

   assign lvl_rdata = lvl_q_ff;
   assign len_rdata = len_q_vld_ff ? len_q_ff : '0;

endmodule

>>> src/lsa_blend.sv
module lsa_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  lsa_pkg::blend_req_type blend_req,
   output lsa_pkg::blend_rsp_type blend_rsp
);

   localparam int SUM_W   = lsa_pkg::BLEND_SUM_W;
   localparam int FRAC_W  = lsa_pkg::FRAC_W;
   localparam int LIGHT_W = lsa_pkg::LIGHT_W;
   localparam int PROD_W  = SUM_W + 1;
   localparam int SCL_W   = SUM_W + 5;

   logic [FRAC_W:0]  wgt1;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic             sum_vld_ff;
   logic [SCL_W-1:0] scaled;
   logic [LIGHT_W-1:0] val_ff;
   logic             val_vld_ff;

   assign wgt1   = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, blend_req.frac};
   assign sum_in = SUM_W'(PROD_W'(blend_req.k1) * PROD_W'(wgt1)
                        + PROD_W'(blend_req.k2) * PROD_W'(blend_req.frac));
   assign scaled = SCL_W'(sum_ff) * SCL_W'(lsa_pkg::STEP_LIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
         val_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= blend_req.start;
         val_vld_ff <= sum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (blend_req.start) begin
         sum_ff <= sum_in;
      end
      if (sum_vld_ff) begin
         val_ff <= LIGHT_W'(scaled >> FRAC_W);
      end
   end

   assign blend_rsp.done  = val_vld_ff;
   assign blend_rsp.value = val_ff;

endmodule
